### hdl/ogru_pkg.sv
package ogru_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_W     = 12;
  localparam int OUT_COUNT_W = 16;
  localparam int UPD_W       = 13;
  localparam int WEIGHT_W    = 8;

  // Operation codes.
  localparam logic OP_RAY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Cell class codes.
  localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
  localparam logic [1:0] CLASS_FREE     = 2'd1;
  localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

  // Reset value of the occupied weight register.
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd10;

  // One input item.
  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } ogru_in_t;

  // One result item.
  typedef struct packed {
    logic [OUT_COUNT_W-1:0] hit_count;
    logic [OUT_COUNT_W-1:0] pass_count;
    logic [1:0]             cell_class;
    logic [UPD_W-1:0]       cells_updated;
    logic                   outside_map;
  } ogru_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RD_CLASS,
    ST_EMIT
  } ogru_state_t;

endpackage

### hdl/occupancy_grid_ray_update.sv
// Occupancy grid with ray updates. Two count grids (hit and pass) of GRID_W x GRID_H cells
// live in two single-port-write, registered-read memories. After reset the block runs a
// clearing pass over all GRID_W*GRID_H cells, one cell per cycle, during which in_stall
// stays high; occupied weight writes are taken at any time. A ray transfer walks the
// 4-connected line from start to end cell at one cell per cycle through a read-modify-write
// pipeline on the grid memories. A read transfer goes through address, weight multiply on
// the memory data, classify and result states. One item is processed at a time; the result
// sits in an output register, and the next item is accepted while that result waits to be
// taken.
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int GRID_W     = 512,
  parameter int GRID_H     = 512,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ogru_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ogru_out_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [WEIGHT_W-1:0] cfg_wr_data
);

  localparam int CELLS  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = COORD_W + 1;
  localparam int LIN_W  = $clog2(GRID_W) + COORD_W + 2;
  localparam int ERR_W  = COORD_W + 3;
  localparam int STEP_W = COORD_W + 1;
  localparam int PROD_W = COUNT_BITS + WEIGHT_W;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [POS_W-1:0] GW_S      = POS_W'(GRID_W);
  localparam logic signed [POS_W-1:0] GH_S      = POS_W'(GRID_H);
  localparam logic signed [LIN_W-1:0] GW_LIN    = LIN_W'(GRID_W);
  localparam logic [ADDR_W-1:0]       LAST_CELL = ADDR_W'(CELLS - 1);

  // Saturating increment of one counter.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  // Clamp a counter to the 16-bit result field.
  function automatic logic [OUT_COUNT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_COUNT_W-1:0] ext;
    ext = {{OUT_COUNT_W{1'b0}}, v};
    return (ext > {{COUNT_BITS{1'b0}}, {OUT_COUNT_W{1'b1}}}) ? {OUT_COUNT_W{1'b1}}
                                                             : ext[OUT_COUNT_W-1:0];
  endfunction

  // Grid memories.
  logic [COUNT_BITS-1:0] hit_mem  [CELLS];
  logic [COUNT_BITS-1:0] pass_mem [CELLS];

  ogru_state_t state_r, state_nxt;

  logic [WEIGHT_W-1:0]     weight_r;
  logic [ADDR_W-1:0]       clr_r;
  logic signed [POS_W-1:0] x_r, y_r;
  logic signed [LIN_W-1:0] lin_r;
  logic signed [ERR_W-1:0] err_r;
  logic [COORD_W-1:0]      dx_r, dy_r;
  logic                    xs_neg_r, ys_neg_r;
  logic [STEP_W-1:0]       steps_r;
  logic [UPD_W-1:0]        upd_r;
  logic                    pend_valid_r, pend_hit_r;
  logic [ADDR_W-1:0]       pend_addr_r;
  logic [COUNT_BITS-1:0]   hit_rd_r, pass_rd_r;
  logic [PROD_W-1:0]       prod_r;
  ogru_out_t               res_r;
  logic                    out_valid_r;
  ogru_out_t               out_data_r;

  logic                  in_accept;
  logic                  pos_in_map;
  logic                  out_free;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  hit_we, pass_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] hit_wdata, pass_wdata;
  logic [UPD_W-1:0]      upd_nxt;
  ogru_out_t             ray_res, read_res;

  // Geometry of a new ray, worked out at the transfer.
  logic signed [POS_W-1:0] sx_s, sy_s, ex_s, ey_s, ddx_s, ddy_s;
  logic [COORD_W-1:0]      dx_abs, dy_abs;
  logic signed [LIN_W-1:0] lin_start;

  always_comb begin
    sx_s      = POS_W'(in_data.start_x);
    sy_s      = POS_W'(in_data.start_y);
    ex_s      = POS_W'(in_data.end_x);
    ey_s      = POS_W'(in_data.end_y);
    ddx_s     = ex_s - sx_s;
    ddy_s     = ey_s - sy_s;
    dx_abs    = ddx_s[POS_W-1] ? COORD_W'(-ddx_s) : COORD_W'(ddx_s);
    dy_abs    = ddy_s[POS_W-1] ? COORD_W'(-ddy_s) : COORD_W'(ddy_s);
    lin_start = LIN_W'(LIN_W'(in_data.start_y) * GW_LIN) + LIN_W'(in_data.start_x);
  end

  // Current walk position against the grid bounds.
  assign pos_in_map = (x_r >= 0) && (x_r < GW_S) && (y_r >= 0) && (y_r < GH_S);
  assign upd_nxt    = upd_r + UPD_W'(pos_in_map);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_accept  = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == LAST_CELL) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) begin
        state_nxt = (in_data.operation == OP_READ) ? ST_RD_ADDR : ST_WALK;
      end
      ST_WALK:     if (steps_r == STEP_W'(1)) state_nxt = ST_EMIT;
      ST_RD_ADDR:  state_nxt = ST_RD_DATA;
      ST_RD_DATA:  state_nxt = ST_RD_CLASS;
      ST_RD_CLASS: state_nxt = ST_EMIT;
      ST_EMIT:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and memory port selection.
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    rd_en      = ((state_r == ST_WALK) || (state_r == ST_RD_ADDR)) && pos_in_map;
    rd_addr    = lin_r[ADDR_W-1:0];
    hit_we     = 1'b0;
    pass_we    = 1'b0;
    wr_addr    = pend_addr_r;
    hit_wdata  = sat_inc(hit_rd_r);
    pass_wdata = sat_inc(pass_rd_r);
    if (state_r == ST_CLEAR) begin
      hit_we     = 1'b1;
      pass_we    = 1'b1;
      wr_addr    = clr_r;
      hit_wdata  = '0;
      pass_wdata = '0;
    end else begin
      hit_we  = pend_valid_r && pend_hit_r;
      pass_we = pend_valid_r && !pend_hit_r;
    end
  end

  // Result words for the end of a ray and for a classified read.
  always_comb begin
    ray_res               = '0;
    ray_res.cells_updated = upd_nxt;
    read_res              = '0;
    if (!pos_in_map) begin
      read_res.outside_map = 1'b1;
    end else begin
      read_res.hit_count  = clamp_out(hit_rd_r);
      read_res.pass_count = clamp_out(pass_rd_r);
      if (prod_r > PROD_W'(pass_rd_r)) begin
        read_res.cell_class = CLASS_OCCUPIED;
      end else if (pass_rd_r != '0) begin
        read_res.cell_class = CLASS_FREE;
      end else begin
        read_res.cell_class = CLASS_UNKNOWN;
      end
    end
  end

  // Grid memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[wr_addr] <= hit_wdata;
    if (pass_we) pass_mem[wr_addr] <= pass_wdata;
    if (rd_en) begin
      hit_rd_r  <= hit_mem[rd_addr];
      pass_rd_r <= pass_mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      weight_r     <= WEIGHT_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= (state_r == ST_WALK) && pos_in_map;
      if (state_r == ST_CLEAR) clr_r <= clr_r + ADDR_W'(1);
      if (cfg_wr_en) weight_r <= cfg_wr_data;
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk and read datapath.
  always_ff @(posedge clk) begin
    pend_hit_r  <= (steps_r == STEP_W'(1));
    pend_addr_r <= lin_r[ADDR_W-1:0];
    if (in_accept) begin
      x_r      <= sx_s;
      y_r      <= sy_s;
      lin_r    <= lin_start;
      dx_r     <= dx_abs;
      dy_r     <= dy_abs;
      xs_neg_r <= !(ddx_s > 0);
      ys_neg_r <= !(ddy_s > 0);
      err_r    <= ERR_W'(dx_abs) - ERR_W'(dy_abs);
      steps_r  <= STEP_W'(dx_abs) + STEP_W'(dy_abs) + STEP_W'(1);
      upd_r    <= '0;
    end else if (state_r == ST_WALK) begin
      // Step in x on a positive error term, otherwise in y.
      if (err_r > 0) begin
        x_r   <= xs_neg_r ? x_r - POS_W'(1) : x_r + POS_W'(1);
        lin_r <= xs_neg_r ? lin_r - LIN_W'(1) : lin_r + LIN_W'(1);
        err_r <= err_r - ERR_W'({dy_r, 1'b0});
      end else begin
        y_r   <= ys_neg_r ? y_r - POS_W'(1) : y_r + POS_W'(1);
        lin_r <= ys_neg_r ? lin_r - GW_LIN : lin_r + GW_LIN;
        err_r <= err_r + ERR_W'({dx_r, 1'b0});
      end
      steps_r <= steps_r - STEP_W'(1);
      upd_r   <= upd_nxt;
      if (steps_r == STEP_W'(1)) res_r <= ray_res;
    end
    // Weighted hit count for the occupied test.
    if (state_r == ST_RD_DATA) prod_r <= PROD_W'(hit_rd_r) * PROD_W'(weight_r);
    // Classify the read cell.
    if (state_r == ST_RD_CLASS) res_r <= read_res;
    if ((state_r == ST_EMIT) && out_free) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A write-back never meets a read of the same cell in one cycle.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && rd_en) |-> (rd_addr != pend_addr_r))
    else $error("read of a cell whose update is still pending");

  // The walk never runs with its step count spent.
  a_walk_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (steps_r != '0))
    else $error("walk running with no steps left");

  // The clearing pass sees no pending update and no result.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!pend_valid_r && !out_valid_r))
    else $error("activity during clearing pass");

  // A new result appears only out of the emit state.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result raised outside the emit state");

endmodule

### bench/occupancy_grid_ray_update_test.sv
`timescale 1ns / 1ps

module occupancy_grid_ray_update_test;
  import ogru_pkg::*;

  localparam int MAP_W = 512;
  localparam int MAP_H = 512;
  localparam int CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam int CLK_PERIOD = 12;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int MAX_GAP = 19;
  localparam int MAX_REPORTS = 200;
  localparam int STACK_RAYS = 30;
  localparam int PHASE_ITEMS = 85;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ogru_in_t in_data;
  logic out_valid;
  logic out_stall;
  ogru_out_t out_data;
  logic cfg_wr_en;
  logic [WEIGHT_W-1:0] cfg_wr_data;

  // Shadow copy of the two count grids and the weight register.
  logic [CNT_BITS-1:0] hit_map [MAP_W*MAP_H];
  logic [CNT_BITS-1:0] pass_map [MAP_W*MAP_H];
  logic [WEIGHT_W-1:0] weight_copy;

  ogru_out_t pending_results [$];
  int error_count;
  int report_count;
  int cycle_count;
  bit sender_idles;
  bit receiver_idles;
  int hub_x;
  int hub_y;
  int last_end_x;
  int last_end_y;

  occupancy_grid_ray_update #(
    .GRID_W(MAP_W),
    .GRID_H(MAP_H),
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic bit on_map(int x, int y);
    return x >= 0 && x < MAP_W && y >= 0 && y < MAP_H;
  endfunction

  // Walk the 4-connected line and bump the shadow counts; returns cells counted.
  function automatic int walk_ray(int sx, int sy, int ex, int ey);
    int dx, dy, xs, ys, err, steps, x, y, idx, updated;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    xs = (ex > sx) ? 1 : -1;
    ys = (ey > sy) ? 1 : -1;
    err = dx - dy;
    x = sx;
    y = sy;
    updated = 0;
    for (steps = 1 + dx + dy; steps > 0; steps--) begin
      if (on_map(x, y)) begin
        idx = y * MAP_W + x;
        if (steps == 1) begin
          if (hit_map[idx] != CNT_MAX) hit_map[idx] = hit_map[idx] + CNT_BITS'(1);
        end else if (pass_map[idx] != CNT_MAX) begin
          pass_map[idx] = pass_map[idx] + CNT_BITS'(1);
        end
        updated++;
      end
      // A tie on the error term steps in y.
      if (err > 0) begin
        x += xs;
        err -= 2 * dy;
      end else begin
        y += ys;
        err += 2 * dx;
      end
    end
    return updated;
  endfunction

  // Expected result of one accepted item, updating the shadow grids for rays.
  function automatic ogru_out_t predict_result(ogru_in_t item);
    ogru_out_t res;
    int sx, sy, idx;
    longint weighted;
    res = '0;
    sx = $signed(item.start_x);
    sy = $signed(item.start_y);
    if (item.operation == OP_RAY) begin
      res.cells_updated = UPD_W'(walk_ray(sx, sy, $signed(item.end_x), $signed(item.end_y)));
    end else if (!on_map(sx, sy)) begin
      res.outside_map = 1'b1;
    end else begin
      idx = sy * MAP_W + sx;
      weighted = longint'(hit_map[idx]) * longint'(weight_copy);
      if (weighted > longint'(pass_map[idx])) res.cell_class = CLASS_OCCUPIED;
      else if (pass_map[idx] != '0) res.cell_class = CLASS_FREE;
      else res.cell_class = CLASS_UNKNOWN;
      res.hit_count = hit_map[idx];
      res.pass_count = pass_map[idx];
    end
    return res;
  endfunction

  function automatic ogru_in_t make_item(logic op, int sx, int sy, int ex, int ey);
    ogru_in_t item;
    item.operation = op;
    item.start_x = COORD_W'(sx);
    item.start_y = COORD_W'(sy);
    item.end_x = COORD_W'(ex);
    item.end_y = COORD_W'(ey);
    return item;
  endfunction

  // Mostly near the hub, some at the map borders, a few anywhere in range.
  function automatic int pick_coord(int hub);
    unique case ($urandom_range(0, 19))
      0: return $signed(COORD_W'($urandom));
      1, 2: return int'($urandom_range(0, 7)) - 4;
      3, 4: return MAP_W - 4 + int'($urandom_range(0, 7));
      default: return hub + int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic ogru_in_t random_item();
    int sx, sy;
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 2) == 0) begin
        sx = last_end_x;
        sy = last_end_y;
      end else begin
        sx = pick_coord(hub_x);
        sy = pick_coord(hub_y);
      end
      // The end fields of a read carry random noise.
      return make_item(OP_READ, sx, sy, $signed(COORD_W'($urandom)),
                       $signed(COORD_W'($urandom)));
    end
    return make_item(OP_RAY, pick_coord(hub_x), pick_coord(hub_y),
                     pick_coord(hub_x), pick_coord(hub_y));
  endfunction

  // Offer one item and queue its expected result once the transfer happens.
  task automatic send_item(ogru_in_t item);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.insert(pending_results.size(), predict_result(item));
    if (item.operation == OP_RAY) begin
      last_end_x = $signed(item.end_x);
      last_end_y = $signed(item.end_y);
    end
  endtask

  task automatic send_ray(int sx, int sy, int ex, int ey);
    send_item(make_item(OP_RAY, sx, sy, ex, ey));
  endtask

  task automatic send_read(int x, int y);
    send_item(make_item(OP_READ, x, y, $signed(COORD_W'($urandom)),
                        $signed(COORD_W'($urandom))));
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_weight(logic [WEIGHT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    weight_copy = value;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    ogru_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("hit_count", want.hit_count, out_data.hit_count);
        compare_field("pass_count", want.pass_count, out_data.pass_count);
        compare_field("cell_class", want.cell_class, out_data.cell_class);
        compare_field("cells_updated", want.cells_updated, out_data.cells_updated);
        compare_field("outside_map", want.outside_map, out_data.outside_map);
      end
    end
  end

  // Receiver stall: after each result transfer hold off for a random number of cycles.
  initial begin : result_stall
    int hold;
    out_stall = 1'b0;
    forever begin
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      hold = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("occupancy_grid_ray_update_test: errors");
    $finish;
  end

  // Reads right after reset see an empty map.
  task automatic test_cleared_map();
    send_read(0, 0);
    send_read(MAP_W - 1, MAP_H - 1);
    send_read(-1, MAP_H - 1);
    send_read(MAP_W, 0);
  endtask

  // Ray shapes: single cell, tie, both slopes, both directions, map edges, extremes.
  task automatic test_ray_shapes();
    send_ray(5, 5, 5, 5);
    send_ray(10, 10, 13, 13);
    send_ray(20, 30, 27, 32);
    send_ray(40, 40, 37, 30);
    send_ray(60, 7, 50, 7);
    send_ray(70, 0, 70, 9);
    send_ray(-3, 2, 4, -2);
    send_ray(508, 100, 515, 101);
    send_ray(-2048, -2048, 2047, 2047);
    send_ray(2047, -2048, 1800, -1900);
    send_read(5, 5);
    send_read(10, 11);
    send_read(13, 13);
    send_read(511, 101);
    send_read(0, 0);
    send_read(-2048, 2047);
  endtask

  // One cell with one hit and one pass sits right on the occupied threshold.
  task automatic test_weight_threshold();
    send_ray(99, 100, 100, 100);
    send_ray(100, 100, 101, 100);
    send_read(100, 100);
    write_weight(8'd1);
    send_read(100, 100);
    write_weight(8'd2);
    send_read(100, 100);
    write_weight(8'd0);
    send_read(100, 100);
    write_weight(8'hFF);
    send_read(100, 100);
  endtask

  // Stack counts on one pass cell and one hit cell with back to back rays.
  task automatic test_count_stacking();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    write_weight(WEIGHT_RESET);
    for (int n = 0; n < STACK_RAYS; n++) send_ray(200, 300, 201, 300);
    send_ray(199, 300, 202, 300);
    send_read(200, 300);
    send_read(201, 300);
    write_weight(8'hFF);
    send_read(201, 300);
    write_weight(8'd0);
    send_read(201, 300);
    send_read(200, 300);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Random traffic in phases, each with its own hub and weight.
  task automatic test_random_traffic();
    logic [WEIGHT_W-1:0] phase_weight [5];
    phase_weight[0] = WEIGHT_RESET;
    phase_weight[1] = 8'd0;
    phase_weight[2] = 8'hFF;
    phase_weight[3] = WEIGHT_W'($urandom);
    phase_weight[4] = 8'd1;
    for (int phase = 0; phase < 5; phase++) begin
      write_weight(phase_weight[phase]);
      hub_x = $urandom_range(20, MAP_W - 21);
      hub_y = $urandom_range(20, MAP_H - 21);
      sender_idles = (phase != 3);
      receiver_idles = (phase != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Sequence of tests.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    report_count = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hub_x = MAP_W / 2;
    hub_y = MAP_H / 2;
    last_end_x = 0;
    last_end_y = 0;
    weight_copy = WEIGHT_RESET;
    for (int i = 0; i < MAP_W * MAP_H; i++) begin
      hit_map[i] = '0;
      pass_map[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cleared_map();
    test_ray_shapes();
    test_weight_threshold();
    test_count_stacking();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("occupancy_grid_ray_update_test: clean");
    end else begin
      $display("occupancy_grid_ray_update_test: errors");
    end
    $finish;
  end

endmodule
